### sv/sot_pkg.sv
// shared types and constants of the stop / oco trigger table
// no dependencies
`default_nettype none
package sot_pkg;

  localparam int SLOTS_DEF = 16;

  typedef enum logic [2:0] {
    OP_STOP   = 3'd0,
    OP_OCO    = 3'd1,
    OP_CANCEL = 3'd2,
    OP_QUOTE  = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    K_PLACED    = 3'd0,
    K_REJECTED  = 3'd1,
    K_CANCELLED = 3'd2,
    K_NOT_FOUND = 3'd3,
    K_PRESENT   = 3'd4,
    K_ABSENT    = 3'd5,
    K_FILL      = 3'd6,
    K_DONE      = 3'd7
  } kind_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] symbol;
    logic        oco;
    logic        buy;
    logic [31:0] stop;
    logic [31:0] take;
    logic [31:0] qty;
    logic [15:0] strategy;
    logic [31:0] oid;
    logic [15:0] qsym;
    logic [31:0] bid;
    logic [31:0] ask;
  } cell_cmd_t;

  typedef struct packed {
    logic        fire;
    logic        reason;
    logic [31:0] level;
    logic [31:0] id;
    logic        oco;
    logic        buy;
    logic [31:0] qty;
    logic [15:0] strategy;
  } cell_sel_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] result_id;
    logic        fill_is_oco;
    logic        fill_reason;
    logic        fill_is_buy;
    logic [31:0] trigger_level;
    logic [31:0] exec_price;
    logic [31:0] fill_qty;
    logic [15:0] fill_strategy;
    logic [47:0] fill_time;
    logic [4:0]  fill_count;
    logic        last;
  } rsp_t;

endpackage
`default_nettype wire

### sv/sot_in_if.sv
// request channel of the trigger table
// no dependencies
`default_nettype none
interface sot_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] symbol_id;
  logic        is_buy;
  logic [31:0] stop_price;
  logic [31:0] take_profit_price;
  logic [31:0] order_qty;
  logic [15:0] strategy_tag;
  logic [31:0] order_id;
  logic [31:0] bid_price;
  logic [31:0] ask_price;
  logic        quote_valid;
  logic [47:0] quote_time;

  modport source (output valid, opcode, symbol_id, is_buy, stop_price, take_profit_price,
                  order_qty, strategy_tag, order_id, bid_price, ask_price, quote_valid,
                  quote_time, input ready);
  modport sink (input valid, opcode, symbol_id, is_buy, stop_price, take_profit_price,
                order_qty, strategy_tag, order_id, bid_price, ask_price, quote_valid,
                quote_time, output ready);
endinterface
`default_nettype wire

### sv/sot_out_if.sv
// result channel of the trigger table
// no dependencies
`default_nettype none
interface sot_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] result_id;
  logic        fill_is_oco;
  logic        fill_reason;
  logic        fill_is_buy;
  logic [31:0] trigger_level;
  logic [31:0] exec_price;
  logic [31:0] fill_qty;
  logic [15:0] fill_strategy;
  logic [47:0] fill_time;
  logic [4:0]  fill_count;
  logic        last;

  modport source (output valid, kind, result_id, fill_is_oco, fill_reason, fill_is_buy,
                  trigger_level, exec_price, fill_qty, fill_strategy, fill_time,
                  fill_count, last, input ready);
  modport sink (input valid, kind, result_id, fill_is_oco, fill_reason, fill_is_buy,
                trigger_level, exec_price, fill_qty, fill_strategy, fill_time,
                fill_count, last, output ready);
endinterface
`default_nettype wire

### sv/stop_oco_trigger_table.sv
// stop / oco trigger table: place, cancel and query give one result each
// a quote scans the slot row with a token, one slot per cycle, but holds at a firing slot
// while the result side stalls; results leave through one output register
// reset (rst, synchronous) empties all slots, refills the free stack and sets next id to 1
// depends on sot_pkg, sot_in_if, sot_out_if, sot_cell
`default_nettype none
module stop_oco_trigger_table #(
  parameter int SLOTS = sot_pkg::SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sot_in_if.sink   req,
  sot_out_if.source rsp
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t             state;
  logic [IW-1:0]      fstack [SLOTS];
  logic [CW-1:0]      ftop;
  logic [CW-1:0]      ftop_m1;
  logic [31:0]        next_id;
  logic [IW-1:0]      scan_idx;
  logic [CW-1:0]      cnt;
  logic [15:0]        q_sym;
  logic [31:0]        q_bid;
  logic [31:0]        q_ask;
  logic [47:0]        q_time;
  logic               rsp_valid;
  sot_pkg::rsp_t      rsp_q;
  sot_pkg::rsp_t      rsp_d;
  logic               rsp_load;

  sot_pkg::cell_cmd_t cmd;
  sot_pkg::cell_sel_t sel [SLOTS];
  sot_pkg::cell_sel_t cur;
  logic [SLOTS-1:0]   wr;
  logic [SLOTS-1:0]   kill;
  logic [SLOTS-1:0]   hit;
  logic [SLOTS-1:0]   hit_oh;
  logic [SLOTS-1:0]   used;
  logic [SLOTS-1:0]   tok;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      pop_idx;

  logic out_free, accept, is_place, is_oco, bad, found;
  logic do_place, do_cancel, do_quote, scan_fire, adv, tok_start, push_en;
  logic [IW-1:0] push_idx;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign is_oco   = req.opcode == sot_pkg::OP_OCO;
  assign is_place = (req.opcode == sot_pkg::OP_STOP) || is_oco;
  assign bad      = (req.symbol_id == 16'd0) || (req.stop_price == 32'd0) ||
                    (is_oco && req.take_profit_price == 32'd0) || (ftop == CW'(0));
  assign ftop_m1  = ftop - CW'(1);
  assign pop_idx  = fstack[ftop_m1[IW-1:0]];

  assign do_place  = accept && is_place && !bad;
  assign do_cancel = accept && (req.opcode == sot_pkg::OP_CANCEL) && found;
  assign do_quote  = accept && (req.opcode == sot_pkg::OP_QUOTE) && req.quote_valid;

  always_comb begin
    cmd          = '0;
    cmd.id       = next_id;
    cmd.symbol   = req.symbol_id;
    cmd.oco      = is_oco;
    cmd.buy      = req.is_buy;
    cmd.stop     = req.stop_price;
    cmd.take     = req.take_profit_price;
    cmd.qty      = req.order_qty;
    cmd.strategy = req.strategy_tag;
    cmd.oid      = req.order_id;
    cmd.qsym     = q_sym;
    cmd.bid      = q_bid;
    cmd.ask      = q_ask;
  end

  assign hit_oh = hit & (~hit + SLOTS'(1));
  assign found  = |hit;

  always_comb begin
    hit_idx = '0;
    cur     = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (hit_oh[k]) begin
        hit_idx = hit_idx | IW'(k);
      end
      cur = sot_pkg::cell_sel_t'(cur | sel[k]);
    end
  end

  assign scan_fire = (state == ST_SCAN) && cur.fire && out_free;
  assign tok_start = do_quote;
  assign adv       = do_quote || ((state == ST_SCAN) && (!cur.fire || out_free));
  assign push_en   = do_cancel || scan_fire;
  assign push_idx  = scan_fire ? scan_idx : hit_idx;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      wr[k]   = do_place && (pop_idx == IW'(k));
      kill[k] = (do_cancel && hit_oh[k]) || (scan_fire && (scan_idx == IW'(k)));
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic tin;
    if (k == 0) begin : g_head
      assign tin = tok_start;
    end else begin : g_link
      assign tin = tok[k-1];
    end
    sot_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .wr      (wr[k]),
      .kill    (kill[k]),
      .tok_in  (tin),
      .adv     (adv),
      .tok_out (tok[k]),
      .hit     (hit[k]),
      .used_o  (used[k]),
      .sel     (sel[k])
    );
  end

  always_comb begin
    rsp_d      = '0;
    rsp_d.last = 1'b1;
    rsp_load   = 1'b0;
    if (accept) begin
      rsp_load        = !do_quote;
      rsp_d.result_id = req.order_id;
      unique case (req.opcode)
        sot_pkg::OP_STOP, sot_pkg::OP_OCO: begin
          rsp_d.kind      = bad ? sot_pkg::K_REJECTED : sot_pkg::K_PLACED;
          rsp_d.result_id = bad ? 32'd0 : next_id;
        end
        sot_pkg::OP_CANCEL: begin
          rsp_d.kind = found ? sot_pkg::K_CANCELLED : sot_pkg::K_NOT_FOUND;
        end
        sot_pkg::OP_QUERY: begin
          rsp_d.kind = found ? sot_pkg::K_PRESENT : sot_pkg::K_ABSENT;
        end
        sot_pkg::OP_QUOTE: begin
          rsp_d.kind      = sot_pkg::K_DONE;
          rsp_d.result_id = 32'd0;
        end
        default: begin
          rsp_d.kind      = sot_pkg::K_REJECTED;
          rsp_d.result_id = 32'd0;
        end
      endcase
    end else if (scan_fire) begin
      rsp_load            = 1'b1;
      rsp_d.kind          = sot_pkg::K_FILL;
      rsp_d.result_id     = cur.id;
      rsp_d.fill_is_oco   = cur.oco;
      rsp_d.fill_reason   = cur.reason;
      rsp_d.fill_is_buy   = cur.buy;
      rsp_d.trigger_level = cur.level;
      rsp_d.exec_price    = cur.buy ? q_ask : q_bid;
      rsp_d.fill_qty      = cur.qty;
      rsp_d.fill_strategy = cur.strategy;
      rsp_d.fill_time     = q_time;
      rsp_d.last          = 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_load         = 1'b1;
      rsp_d.kind       = sot_pkg::K_DONE;
      rsp_d.fill_count = 5'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      ftop      <= CW'(SLOTS);
      next_id   <= 32'd1;
      scan_idx  <= '0;
      cnt       <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        fstack[k] <= IW'(SLOTS - 1 - k);
      end
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_q     <= rsp_d;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (do_place) begin
        ftop    <= ftop_m1;
        next_id <= next_id + 32'd1;
      end else if (push_en && ftop < CW'(SLOTS)) begin
        fstack[ftop[IW-1:0]] <= push_idx;
        ftop                 <= ftop + CW'(1);
      end
      if (accept) begin
        q_sym  <= req.symbol_id;
        q_bid  <= req.bid_price;
        q_ask  <= req.ask_price;
        q_time <= req.quote_time;
      end
      unique case (state)
        ST_IDLE: begin
          if (do_quote) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
            cnt      <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_fire) begin
            cnt <= cnt + CW'(1);
          end
          if (adv) begin
            if (scan_idx == IW'(SLOTS - 1)) begin
              state <= ST_DONE;
            end else begin
              scan_idx <= scan_idx + IW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.kind          = rsp_q.kind;
  assign rsp.result_id     = rsp_q.result_id;
  assign rsp.fill_is_oco   = rsp_q.fill_is_oco;
  assign rsp.fill_reason   = rsp_q.fill_reason;
  assign rsp.fill_is_buy   = rsp_q.fill_is_buy;
  assign rsp.trigger_level = rsp_q.trigger_level;
  assign rsp.exec_price    = rsp_q.exec_price;
  assign rsp.fill_qty      = rsp_q.fill_qty;
  assign rsp.fill_strategy = rsp_q.fill_strategy;
  assign rsp.fill_time     = rsp_q.fill_time;
  assign rsp.fill_count    = rsp_q.fill_count;
  assign rsp.last          = rsp_q.last;

  a_free_bound: assert property (@(posedge clk) disable iff (rst) ftop <= CW'(SLOTS))
    else $error("free stack count above slot count");
  a_free_used: assert property (@(posedge clk) disable iff (rst)
    ($countones(used) + int'(ftop)) == SLOTS)
    else $error("used slots and free stack disagree");
  a_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok))
    else $error("more than one scan token");
  a_scan_tok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> tok[scan_idx])
    else $error("scan token not at scan index");

endmodule
`default_nettype wire

### sv/sot_cell.sv
// one order slot of the table, with its trigger compare and scan token
// depends on sot_pkg
`default_nettype none
module sot_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sot_pkg::cell_cmd_t  cmd,
  input  wire logic                wr,
  input  wire logic                kill,
  input  wire logic                tok_in,
  input  wire logic                adv,
  output logic                     tok_out,
  output logic                     hit,
  output logic                     used_o,
  output sot_pkg::cell_sel_t       sel
);
  logic        used;
  logic        tok;
  logic [31:0] id;
  logic [15:0] symbol;
  logic        oco;
  logic        buy;
  logic [31:0] stop;
  logic [31:0] take;
  logic [31:0] qty;
  logic [15:0] strategy;
  logic        stop_hit;
  logic        take_hit;
  logic        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      tok  <= 1'b0;
    end else begin
      if (wr) begin
        used <= 1'b1;
      end else if (kill) begin
        used <= 1'b0;
      end
      if (adv) begin
        tok <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      id       <= cmd.id;
      symbol   <= cmd.symbol;
      oco      <= cmd.oco;
      buy      <= cmd.buy;
      stop     <= cmd.stop;
      take     <= cmd.take;
      qty      <= cmd.qty;
      strategy <= cmd.strategy;
    end
  end

  always_comb begin
    stop_hit = buy ? (cmd.ask >= stop) : (cmd.bid <= stop);
    take_hit = oco && (buy ? (cmd.bid <= take) : (cmd.ask >= take));
    fire     = used && (symbol == cmd.qsym) && (stop_hit || take_hit);
    sel      = '0;
    if (tok) begin
      sel.fire     = fire;
      sel.reason   = !stop_hit;
      sel.level    = stop_hit ? stop : take;
      sel.id       = id;
      sel.oco      = oco;
      sel.buy      = buy;
      sel.qty      = qty;
      sel.strategy = strategy;
    end
  end

  assign hit     = used && (id == cmd.oid);
  assign used_o  = used;
  assign tok_out = tok;

endmodule
`default_nettype wire

### tb/tb_stop_oco_trigger_table.sv
// testbench for the stop / oco trigger table: random and directed requests, results
// checked in order against a behavioral table kept in a scoreboard class
// depends on sot_pkg, sot_in_if, sot_out_if, stop_oco_trigger_table
`timescale 1ns / 100ps
`default_nettype none
module tb_stop_oco_trigger_table;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]  opcode;
    logic [15:0] symbol_id;
    logic        is_buy;
    logic [31:0] stop_price;
    logic [31:0] take_profit_price;
    logic [31:0] order_qty;
    logic [15:0] strategy_tag;
    logic [31:0] order_id;
    logic [31:0] bid_price;
    logic [31:0] ask_price;
    logic        quote_valid;
    logic [47:0] quote_time;
  } request_t;

  class order_table_board;
    bit              used[NSLOT];
    bit [31:0]       id[NSLOT];
    bit [15:0]       sym[NSLOT];
    bit              oco[NSLOT];
    bit              buy[NSLOT];
    bit [31:0]       stop[NSLOT];
    bit [31:0]       take[NSLOT];
    bit [31:0]       qty[NSLOT];
    bit [15:0]       strat[NSLOT];
    bit [3:0]        free_stack[NSLOT];
    int              free_top;
    bit [31:0]       next_id;
    sot_pkg::rsp_t   pending[$];
    int              errors;
    bit [31:0]       live_ids[$];

    function new();
      for (int k = 0; k < NSLOT; k++) begin
        used[k] = 0;
        free_stack[k] = 4'(NSLOT - 1 - k);
      end
      free_top = NSLOT;
      next_id = 1;
      errors = 0;
    endfunction

    function sot_pkg::rsp_t blank(sot_pkg::kind_t k, logic [31:0] rid);
      sot_pkg::rsp_t r;
      r = '0;
      r.kind = k;
      r.result_id = rid;
      return r;
    endfunction

    function void release_slot(int i);
      used[i] = 0;
      if (free_top < NSLOT) begin
        free_stack[free_top] = 4'(i);
        free_top++;
      end
    endfunction

    function void note_request(request_t q);
      sot_pkg::rsp_t r;
      int hit;
      int cnt;
      bit fire;
      bit why;
      logic [31:0] lvl;
      r = blank(sot_pkg::K_REJECTED, 0);
      case (q.opcode)
        sot_pkg::OP_STOP, sot_pkg::OP_OCO: begin
          if (q.symbol_id != 0 && q.stop_price != 0 &&
              !(q.opcode == sot_pkg::OP_OCO && q.take_profit_price == 0) &&
              free_top != 0) begin
            free_top--;
            hit = free_stack[free_top];
            used[hit] = 1;
            id[hit] = next_id;
            live_ids = {live_ids, next_id};
            next_id++;
            sym[hit] = q.symbol_id;
            oco[hit] = q.opcode == sot_pkg::OP_OCO;
            buy[hit] = q.is_buy;
            stop[hit] = q.stop_price;
            take[hit] = q.opcode == sot_pkg::OP_OCO ? q.take_profit_price : 0;
            qty[hit] = q.order_qty;
            strat[hit] = q.strategy_tag;
            r = blank(sot_pkg::K_PLACED, id[hit]);
          end
        end
        sot_pkg::OP_CANCEL, sot_pkg::OP_QUERY: begin
          hit = -1;
          for (int i = 0; i < NSLOT; i++)
            if (hit < 0 && used[i] && id[i] == q.order_id) hit = i;
          if (q.opcode == sot_pkg::OP_CANCEL) begin
            if (hit >= 0) release_slot(hit);
            r = blank(hit >= 0 ? sot_pkg::K_CANCELLED : sot_pkg::K_NOT_FOUND, q.order_id);
          end else begin
            r = blank(hit >= 0 ? sot_pkg::K_PRESENT : sot_pkg::K_ABSENT, q.order_id);
          end
        end
        sot_pkg::OP_QUOTE: begin
          cnt = 0;
          if (q.quote_valid) begin
            for (int i = 0; i < NSLOT; i++) begin
              if (!used[i] || sym[i] != q.symbol_id) continue;
              fire = 0;
              why = 0;
              lvl = 0;
              if (!buy[i]) begin
                if (q.bid_price <= stop[i]) begin
                  fire = 1; lvl = stop[i];
                end else if (oco[i] && q.ask_price >= take[i]) begin
                  fire = 1; why = 1; lvl = take[i];
                end
              end else begin
                if (q.ask_price >= stop[i]) begin
                  fire = 1; lvl = stop[i];
                end else if (oco[i] && q.bid_price <= take[i]) begin
                  fire = 1; why = 1; lvl = take[i];
                end
              end
              if (!fire) continue;
              r = blank(sot_pkg::K_FILL, id[i]);
              r.fill_is_oco = oco[i];
              r.fill_reason = why;
              r.fill_is_buy = buy[i];
              r.trigger_level = lvl;
              r.exec_price = buy[i] ? q.ask_price : q.bid_price;
              r.fill_qty = qty[i];
              r.fill_strategy = strat[i];
              r.fill_time = q.quote_time;
              pending = {pending, r};
              cnt++;
              release_slot(i);
            end
          end
          r = blank(sot_pkg::K_DONE, 0);
          r.fill_count = 5'(cnt);
        end
        default: ;
      endcase
      r.last = 1;
      pending = {pending, r};
    endfunction

    function void check_result(sot_pkg::rsp_t got);
      sot_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  sot_in_if  req();
  sot_out_if rsp();
  order_table_board board;
  int cycles = 0;
  bit no_idle = 0;
  bit hold_off = 0;
  bit [15:0] syms[4] = '{16'd1, 16'd7, 16'hFFFF, 16'd300};

  always #5 clk = ~clk;

  stop_oco_trigger_table u_top (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  initial begin
    req.valid = 0; req.opcode = 0; req.symbol_id = 0; req.is_buy = 0;
    req.stop_price = 0; req.take_profit_price = 0; req.order_qty = 0;
    req.strategy_tag = 0; req.order_id = 0; req.bid_price = 0; req.ask_price = 0;
    req.quote_valid = 0; req.quote_time = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(sot_pkg::rsp_t'({rsp.kind, rsp.result_id, rsp.fill_is_oco,
                                          rsp.fill_reason, rsp.fill_is_buy,
                                          rsp.trigger_level, rsp.exec_price,
                                          rsp.fill_qty, rsp.fill_strategy, rsp.fill_time,
                                          rsp.fill_count, rsp.last}));

  initial begin
    @(negedge clk);
    while (1) begin
      @(posedge clk);
      @(negedge clk);
      if (hold_off) rsp.ready <= 0;
      else rsp.ready <= !rst && (no_idle || $urandom_range(99) >= 36);
    end
  end

  task automatic send(request_t q);
    req.opcode <= q.opcode; req.symbol_id <= q.symbol_id; req.is_buy <= q.is_buy;
    req.stop_price <= q.stop_price; req.take_profit_price <= q.take_profit_price;
    req.order_qty <= q.order_qty; req.strategy_tag <= q.strategy_tag;
    req.order_id <= q.order_id; req.bid_price <= q.bid_price;
    req.ask_price <= q.ask_price; req.quote_valid <= q.quote_valid;
    req.quote_time <= q.quote_time;
    req.valid <= 1;
    do @(posedge clk); while (!req.ready);
    board.note_request(q);
    @(negedge clk);
    if (!no_idle)
      while ($urandom_range(99) < 36) begin
        req.valid <= 0;
        @(negedge clk);
      end
  endtask

  function automatic request_t noise();
    request_t q;
    q.opcode = 3'($urandom); q.symbol_id = 16'($urandom); q.is_buy = 1'($urandom);
    q.stop_price = $urandom; q.take_profit_price = $urandom; q.order_qty = $urandom;
    q.strategy_tag = 16'($urandom); q.order_id = $urandom; q.bid_price = $urandom;
    q.ask_price = $urandom; q.quote_valid = 1'($urandom);
    q.quote_time = {16'($urandom), 32'($urandom)};
    return q;
  endfunction

  function automatic request_t shaped();
    request_t q;
    int sel;
    q = noise();
    q.symbol_id = syms[$urandom_range(3)];
    q.stop_price = 32'd1000 + $urandom_range(200);
    q.take_profit_price = 32'd1000 + $urandom_range(200);
    q.bid_price = 32'd1000 + $urandom_range(200);
    q.ask_price = 32'd1000 + $urandom_range(200);
    q.quote_valid = $urandom_range(9) != 0;
    sel = $urandom_range(99);
    if (sel < 30) q.opcode = sot_pkg::OP_STOP;
    else if (sel < 55) q.opcode = sot_pkg::OP_OCO;
    else if (sel < 80) q.opcode = sot_pkg::OP_QUOTE;
    else if (sel < 90) q.opcode = sot_pkg::OP_CANCEL;
    else q.opcode = sot_pkg::OP_QUERY;
    if ((q.opcode == sot_pkg::OP_CANCEL || q.opcode == sot_pkg::OP_QUERY) &&
        board.live_ids.size() != 0 && $urandom_range(3) != 0)
      q.order_id = board.live_ids[$urandom_range(board.live_ids.size() - 1)];
    return q;
  endfunction

  initial begin
    request_t q;
    int wait_cycles;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    q = noise();
    q.symbol_id = 16'hFFFF; q.stop_price = 32'hFFFF_FFFF; q.take_profit_price = 32'd1;
    q.is_buy = 1; q.order_qty = 32'hFFFF_FFFF; q.strategy_tag = 16'hFFFF;
    q.opcode = sot_pkg::OP_OCO; send(q);
    q.opcode = sot_pkg::OP_STOP; q.is_buy = 0; q.stop_price = 32'd1; send(q);
    q.symbol_id = 0; send(q);
    q.symbol_id = 16'd5; q.stop_price = 0; send(q);
    q.stop_price = 32'd9; q.take_profit_price = 0; q.opcode = sot_pkg::OP_OCO; send(q);
    q.opcode = sot_pkg::OP_QUERY; q.order_id = 32'd1; send(q);
    q.order_id = 32'hFFFF_FFFF; send(q);
    q.opcode = 3'd5; send(q);
    q.opcode = 3'd7; send(q);
    q.opcode = sot_pkg::OP_QUOTE; q.symbol_id = 16'hFFFF; q.quote_valid = 0; send(q);
    q.quote_valid = 1; q.bid_price = 0; q.ask_price = 0;
    q.quote_time = 48'hFFFF_FFFF_FFFF; send(q);
    q.opcode = sot_pkg::OP_CANCEL; q.order_id = 32'd1; send(q);
    send(q);
    for (int k = 0; k < 17; k++) begin
      q = shaped(); q.opcode = k[0] ? sot_pkg::OP_OCO : sot_pkg::OP_STOP;
      q.symbol_id = 16'd7; send(q);
    end
    q.opcode = sot_pkg::OP_QUOTE; q.symbol_id = 16'd7; q.quote_valid = 1;
    q.bid_price = 32'd0; q.ask_price = 32'hFFFF_FFFF; send(q);
    for (int n = 0; n < 230; n++) begin
      if (n == 60) no_idle = 1;
      if (n == 110) no_idle = 0;
      if (n == 150) begin
        fork
          begin
            hold_off = 1;
            wait_cycles = 0;
            while (wait_cycles < 80) begin
              @(posedge clk);
              wait_cycles++;
            end
            hold_off = 0;
          end
        join_none
      end
      q = $urandom_range(9) == 0 ? noise() : shaped();
      send(q);
    end
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
